[src/ppp_pkg.sv]
// ----------------------------------------------------------------------------
// ppp_pkg
// Shared types and constants of the point to plane projection pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ppp_pkg;

  localparam int DIV_STEPS  = 128;
  localparam int SQRT_STEPS = 64;
  localparam int NUM_W      = 128;
  localparam int DEN_W      = 60;
  localparam int IN_W       = 384;
  localparam int OUT_W      = 128;

  localparam logic [40:0] QM_MAX = 41'h100_0000_0000;

  typedef struct packed {
    logic             deg;
    logic [2:0]       neg;
    logic [2:0][31:0] x;
  } side_t;

  typedef struct packed {
    logic [3:0][NUM_W-1:0] num;
    logic [DEN_W-1:0]      den;
    side_t                 side;
  } div_in_t;

  typedef struct packed {
    logic [3:0][NUM_W-1:0] quot;
    logic [2:0][DEN_W-1:0] rem;
    logic [DEN_W-1:0]      den;
    side_t                 side;
  } div_out_t;

  typedef struct packed {
    logic             deg;
    logic [31:0]      distance;
    logic [2:0][31:0] foot;
  } res_t;

endpackage

`default_nettype wire

[src/ppp_front.sv]
// ----------------------------------------------------------------------------
// ppp_front
// Normal, normalization, dot products and divider operands; nine stages.
// ----------------------------------------------------------------------------
`default_nettype none

module ppp_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    vld_i,
  input  logic [ppp_pkg::IN_W-1:0] data_i,
  output logic                    vld_o,
  output ppp_pkg::div_in_t        data_o
);

  logic [8:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[7:0], vld_i};
    end
  end

  assign vld_o = vld_q[8];

  logic signed [31:0] u [3];
  logic signed [31:0] v [3];
  logic signed [32:0] d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u[i] = data_i[96+32*i +: 32];
      v[i] = data_i[192+32*i +: 32];
      d[i] = $signed({data_i[32*i+31], data_i[32*i +: 32]})
           - $signed({data_i[288+32*i+31], data_i[288+32*i +: 32]});
    end
  end

  logic [95:0] x_q [8];

  logic signed [63:0] p1_q [6];
  logic signed [32:0] d1_q [3];
  logic signed [63:0] n2_q [3];
  logic signed [32:0] d2_q [3];
  logic [63:0]        mag3_q [3];
  logic [2:0]         neg3_q;
  logic signed [32:0] d3_q [3];
  logic [28:0]        mm4_q [3];
  logic [2:0]         neg4_q;
  logic               deg4_q;
  logic signed [32:0] d4_q [3];
  logic signed [62:0] md5_q [3];
  logic [57:0]        sq5_q [3];
  logic [28:0]        mm5_q [3];
  logic [2:0]         neg5_q;
  logic               deg5_q;
  logic signed [64:0] dot6_q;
  logic [59:0]        e6_q;
  logic [28:0]        mm6_q [3];
  logic [2:0]         neg6_q;
  logic               deg6_q;
  logic [63:0]        ad7_q;
  logic               dn7_q;
  logic [59:0]        e7_q;
  logic [28:0]        mm7_q [3];
  logic [2:0]         neg7_q;
  logic               deg7_q;
  logic [60:0]        pl8_q [3];
  logic [60:0]        ph8_q [3];
  logic [63:0]        ll8_q;
  logic [63:0]        lh8_q;
  logic [63:0]        hh8_q;
  logic [59:0]        e8_q;
  logic [2:0]         neg8_q;
  logic               deg8_q;
  ppp_pkg::div_in_t   out_q;

  // normalization shift
  logic [63:0]        all;
  logic [6:0]         len;
  logic [5:0]         sh;
  logic [28:0]        mm_d [3];
  logic signed [29:0] ms [3];
  logic signed [64:0] dot_d;
  logic [59:0]        e_d;
  logic [127:0]       sq_d;

  always_comb begin
    all = mag3_q[0] | mag3_q[1] | mag3_q[2];
    len = '0;
    for (int k = 0; k < 64; k++) begin
      if (all[k]) begin
        len = 7'(k + 1);
      end
    end
    sh = (len > 7'd29) ? 6'(len - 7'd29) : 6'd0;
    for (int i = 0; i < 3; i++) begin
      mm_d[i] = 29'(mag3_q[i] >> sh);
      ms[i]   = neg4_q[i] ? -$signed({1'b0, mm4_q[i]}) : $signed({1'b0, mm4_q[i]});
    end
    dot_d = md5_q[0] + md5_q[1] + md5_q[2];
    e_d   = 60'(sq5_q[0]) + 60'(sq5_q[1]) + 60'(sq5_q[2]);
    sq_d  = 128'(ll8_q) + (128'(lh8_q) << 33) + (128'(hh8_q) << 64);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= data_i[383:288];
      for (int k = 1; k < 8; k++) begin
        x_q[k] <= x_q[k-1];
      end
      p1_q[0] <= u[1] * v[2];
      p1_q[1] <= u[2] * v[1];
      p1_q[2] <= u[2] * v[0];
      p1_q[3] <= u[0] * v[2];
      p1_q[4] <= u[0] * v[1];
      p1_q[5] <= u[1] * v[0];
      for (int i = 0; i < 3; i++) begin
        d1_q[i]   <= d[i];
        n2_q[i]   <= p1_q[2*i] - p1_q[2*i+1];
        d2_q[i]   <= d1_q[i];
        mag3_q[i] <= n2_q[i][63] ? 64'(-n2_q[i]) : 64'(n2_q[i]);
        neg3_q[i] <= n2_q[i][63];
        d3_q[i]   <= d2_q[i];
        mm4_q[i]  <= mm_d[i];
        d4_q[i]   <= d3_q[i];
        md5_q[i]  <= ms[i] * d4_q[i];
        sq5_q[i]  <= mm4_q[i] * mm4_q[i];
        mm5_q[i]  <= mm4_q[i];
        mm6_q[i]  <= mm5_q[i];
        mm7_q[i]  <= mm6_q[i];
        pl8_q[i]  <= mm7_q[i] * ad7_q[31:0];
        ph8_q[i]  <= mm7_q[i] * ad7_q[63:32];
        out_q.num[i] <= 128'(pl8_q[i]) + (128'(ph8_q[i]) << 32);
      end
      neg4_q <= neg3_q;
      deg4_q <= (all == '0);
      neg5_q <= neg4_q;
      deg5_q <= deg4_q;
      dot6_q <= dot_d;
      e6_q   <= e_d;
      neg6_q <= neg5_q;
      deg6_q <= deg5_q;
      ad7_q  <= dot6_q[64] ? 64'(-dot6_q) : 64'(dot6_q);
      dn7_q  <= dot6_q[64];
      e7_q   <= e6_q;
      neg7_q <= neg6_q;
      deg7_q <= deg6_q;
      ll8_q  <= ad7_q[31:0] * ad7_q[31:0];
      lh8_q  <= ad7_q[31:0] * ad7_q[63:32];
      hh8_q  <= ad7_q[63:32] * ad7_q[63:32];
      e8_q   <= e7_q;
      neg8_q <= neg7_q ^ {3{dn7_q}};
      deg8_q <= deg7_q;
      out_q.num[3]    <= {sq_d[125:0], 2'b00};
      out_q.den       <= e8_q;
      out_q.side.deg  <= deg8_q;
      out_q.side.neg  <= neg8_q;
      out_q.side.x    <= x_q[7];
    end
  end

  assign data_o = out_q;

endmodule

`default_nettype wire

[src/ppp_div.sv]
// ----------------------------------------------------------------------------
// ppp_div
// Four-lane restoring divider, one quotient bit per stage, shared divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module ppp_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  ppp_pkg::div_in_t  data_i,
  output logic              vld_o,
  output ppp_pkg::div_out_t data_o
);

  localparam int N = ppp_pkg::DIV_STEPS;
  localparam int W = ppp_pkg::NUM_W;
  localparam int D = ppp_pkg::DEN_W;

  logic [N-1:0]         vld_q;
  logic [3:0][W-1:0]    w_q    [N];
  logic [3:0][D-1:0]    r_q    [N];
  logic [D-1:0]         den_q  [N];
  ppp_pkg::side_t       side_q [N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[N-2:0], vld_i};
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_step
    logic [3:0][W-1:0] w_in;
    logic [3:0][D-1:0] r_in;
    logic [D-1:0]      den_in;
    ppp_pkg::side_t    side_in;
    logic [3:0][D:0]   rs;
    logic [3:0]        ge;
    logic [3:0][W-1:0] w_nx;
    logic [3:0][D-1:0] r_nx;

    if (j == 0) begin : g_first
      assign w_in    = data_i.num;
      assign r_in    = '0;
      assign den_in  = data_i.den;
      assign side_in = data_i.side;
    end else begin : g_next
      assign w_in    = w_q[j-1];
      assign r_in    = r_q[j-1];
      assign den_in  = den_q[j-1];
      assign side_in = side_q[j-1];
    end

    always_comb begin
      for (int l = 0; l < 4; l++) begin
        rs[l]   = {r_in[l], w_in[l][W-1]};
        ge[l]   = rs[l] >= {1'b0, den_in};
        r_nx[l] = ge[l] ? D'(rs[l] - {1'b0, den_in}) : rs[l][D-1:0];
        w_nx[l] = {w_in[l][W-2:0], ge[l]};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        w_q[j]    <= w_nx;
        r_q[j]    <= r_nx;
        den_q[j]  <= den_in;
        side_q[j] <= side_in;
      end
    end
  end

  assign vld_o       = vld_q[N-1];
  assign data_o.quot = w_q[N-1];
  assign data_o.rem  = r_q[N-1][2:0];
  assign data_o.den  = den_q[N-1];
  assign data_o.side = side_q[N-1];

endmodule

`default_nettype wire

[src/ppp_back.sv]
// ----------------------------------------------------------------------------
// ppp_back
// Foot rounding and saturation, pipelined square root, distance output reg.
// ----------------------------------------------------------------------------
`default_nettype none

module ppp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  ppp_pkg::div_out_t data_i,
  output logic              vld_o,
  output ppp_pkg::res_t     data_o
);

  localparam int S = ppp_pkg::SQRT_STEPS;
  localparam int W = ppp_pkg::NUM_W;
  localparam int L = S + 3;

  logic [L-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[L-2:0], vld_i};
    end
  end

  assign vld_o = vld_q[L-1];

  // rounding and clamp of the correction
  logic [2:0][40:0]   qm_d;
  logic [64:0]        qi;
  logic [2:0][40:0]   qm_q;
  logic [W-1:0]       rad_a_q;
  ppp_pkg::side_t     side_a_q;

  always_comb begin
    qi = '0;
    for (int i = 0; i < 3; i++) begin
      qi = 65'(data_i.quot[i][63:0])
         + 65'({data_i.rem[i], 1'b0} >= {1'b0, data_i.den});
      if ((data_i.quot[i][W-1:64] != '0) || (qi > 65'(ppp_pkg::QM_MAX))) begin
        qm_d[i] = ppp_pkg::QM_MAX;
      end else begin
        qm_d[i] = qi[40:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qm_q     <= qm_d;
      rad_a_q  <= data_i.quot[3];
      side_a_q <= data_i.side;
    end
  end

  // foot coordinates
  logic signed [41:0] xe;
  logic signed [41:0] f;
  logic [2:0][31:0]   foot_d;
  logic [2:0][31:0]   foot_b_q;
  logic [W-1:0]       rad_b_q;
  logic               deg_b_q;

  always_comb begin
    xe = '0;
    f  = '0;
    for (int i = 0; i < 3; i++) begin
      xe = $signed({{10{side_a_q.x[i][31]}}, side_a_q.x[i]});
      f  = side_a_q.neg[i] ? xe - $signed({1'b0, qm_q[i]}) : xe + $signed({1'b0, qm_q[i]});
      if (side_a_q.deg) begin
        foot_d[i] = '0;
      end else if (f > 42'sd2147483647) begin
        foot_d[i] = 32'h7fff_ffff;
      end else if (f < -42'sd2147483648) begin
        foot_d[i] = 32'h8000_0000;
      end else begin
        foot_d[i] = f[31:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      foot_b_q <= foot_d;
      rad_b_q  <= rad_a_q;
      deg_b_q  <= side_a_q.deg;
    end
  end

  // digit-by-digit square root, two radicand bits per stage
  logic [W-1:0]     w_q    [S];
  logic [65:0]      rem_q  [S];
  logic [63:0]      root_q [S];
  logic [2:0][31:0] foot_q [S];
  logic             deg_q  [S];

  for (genvar j = 0; j < S; j++) begin : g_root
    logic [W-1:0]     w_in;
    logic [65:0]      rem_in;
    logic [63:0]      root_in;
    logic [2:0][31:0] foot_in;
    logic             deg_in;
    logic [67:0]      remn;
    logic [67:0]      trial;
    logic             ge;

    if (j == 0) begin : g_first
      assign w_in    = rad_b_q;
      assign rem_in  = '0;
      assign root_in = '0;
      assign foot_in = foot_b_q;
      assign deg_in  = deg_b_q;
    end else begin : g_next
      assign w_in    = w_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign foot_in = foot_q[j-1];
      assign deg_in  = deg_q[j-1];
    end

    assign remn  = {rem_in, w_in[W-1:W-2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign ge    = remn >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        w_q[j]    <= {w_in[W-3:0], 2'b00};
        rem_q[j]  <= ge ? 66'(remn - trial) : remn[65:0];
        root_q[j] <= {root_in[62:0], ge};
        foot_q[j] <= foot_in;
        deg_q[j]  <= deg_in;
      end
    end
  end

  logic [63:0]   k;
  logic [63:0]   dist_rnd;
  ppp_pkg::res_t res_q;

  assign k        = root_q[S-1];
  assign dist_rnd = {1'b0, k[63:1]} + 64'(k[0]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q.deg  <= deg_q[S-1];
      res_q.foot <= foot_q[S-1];
      if (deg_q[S-1]) begin
        res_q.distance <= '0;
      end else if (dist_rnd[63:32] != '0) begin
        res_q.distance <= 32'hffff_ffff;
      end else begin
        res_q.distance <= dist_rnd[31:0];
      end
    end
  end

  assign data_o = res_q;

endmodule

`default_nettype wire

[src/point_plane_projection.sv]
// ----------------------------------------------------------------------------
// point_plane_projection
// Projects a point onto a plane given by a base point and two span vectors.
// ----------------------------------------------------------------------------
// Input stream: one transaction per query, twelve signed Q16.16 words on
// s_axis_tdata_i. Output stream: one transaction per query, foot point and
// distance on m_axis_tdata_o, degenerate flag on m_axis_tuser_o.
// The path from input transaction to result has 9 stages for the
// normal, normalization and dot products, 128 stages of the bit-per-stage
// divider, 2 stages of foot rounding, 64 stages of square root and the
// output register. Throughput is one query per cycle while not stalled.
// Reset clears all valid bits; the pipeline is empty and ready afterwards.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_axis_tready_o drops until the result is taken; nothing is lost or
// repeated. While the output register is empty the pipeline keeps moving.
// ----------------------------------------------------------------------------
`default_nettype none

module point_plane_projection (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // plane_point_x/y/z, span_one_x/y/z, span_two_x/y/z, query_x/y/z
  input  logic [383:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // foot_x, foot_y, foot_z, distance
  output logic [127:0] m_axis_tdata_o,
  // degenerate
  output logic         m_axis_tuser_o
);

  logic              en;
  logic              f_vld;
  logic              d_vld;
  ppp_pkg::div_in_t  f_data;
  ppp_pkg::div_out_t d_data;
  ppp_pkg::res_t     res;

  assign en              = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;

  ppp_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s_axis_tvalid_i),
    .data_i (s_axis_tdata_i),
    .vld_o  (f_vld),
    .data_o (f_data)
  );

  ppp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (f_vld),
    .data_i (f_data),
    .vld_o  (d_vld),
    .data_o (d_data)
  );

  ppp_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (d_vld),
    .data_i (d_data),
    .vld_o  (m_axis_tvalid_o),
    .data_o (res)
  );

  assign m_axis_tdata_o = {res.distance, res.foot[2], res.foot[1], res.foot[0]};
  assign m_axis_tuser_o = res.deg;

endmodule

`default_nettype wire
